// ===== rtl/core/hac_pkg.sv =====
// Shared types, constants and normalisation helpers for the helicity-angle cosine core.
package hac_pkg;

  localparam int NORM_BITS    = 30;
  localparam int COS_FRAC     = 30;
  localparam int COS_ONE      = 1 << COS_FRAC;
  localparam int WIDE_BITS    = 96;
  localparam int LEN_BITS     = 7;
  localparam int BOOST_STAGES = 8;

  typedef logic signed [NORM_BITS:0] comp_t;
  typedef comp_t [3:0] vec4_t;
  typedef comp_t [2:0] vec3_t;
  typedef logic [WIDE_BITS-1:0] wide_t;
  typedef logic [LEN_BITS-1:0] len_t;

  typedef struct packed {
    vec4_t par;
    vec4_t mid;
    vec4_t grd;
    logic  ok;
  } frame_tag_t;

  typedef struct packed {
    logic neg;
    logic ok;
    logic sat;
  } div_tag_t;

  function automatic len_t bit_len(input wide_t x);
    len_t len;
    len = '0;
    for (int i = 0; i < WIDE_BITS; i++) begin
      if (x[i]) len = LEN_BITS'(i + 1);
    end
    return len;
  endfunction

  function automatic logic [NORM_BITS-1:0] norm_mag(input wide_t mag, input len_t len);
    wide_t sh;
    if (len > LEN_BITS'(NORM_BITS)) sh = mag >> (len - LEN_BITS'(NORM_BITS));
    else sh = mag << (LEN_BITS'(NORM_BITS) - len);
    return sh[NORM_BITS-1:0];
  endfunction

  function automatic comp_t apply_sign(input logic [NORM_BITS-1:0] m, input logic neg);
    comp_t c;
    c = comp_t'({1'b0, m});
    return neg ? -c : c;
  endfunction

  function automatic logic signed [63:0] smul(input comp_t a, input comp_t b);
    return 64'(a) * 64'(b);
  endfunction

endpackage

// ===== rtl/core/hac_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a side tag.
module hac_isqrt #(
  parameter int IN_BITS  = 62,
  parameter int TAG_BITS = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic [IN_BITS-1:0]    in_x,
  input  logic [TAG_BITS-1:0]   in_tag,
  output logic                  out_vld,
  output logic [IN_BITS/2-1:0]  out_root,
  output logic [TAG_BITS-1:0]   out_tag
);

  localparam int RB = IN_BITS / 2;
  localparam int RW = RB + 2;

  logic                vld_r  [RB];
  logic [IN_BITS-1:0]  x_r    [RB];
  logic [RW-1:0]       rem_r  [RB];
  logic [RB-1:0]       root_r [RB];
  logic [TAG_BITS-1:0] tag_r  [RB];

  for (genvar g = 0; g < RB; g++) begin : g_stage
    logic                src_vld;
    logic [IN_BITS-1:0]  src_x;
    logic [RW-1:0]       src_rem;
    logic [RB-1:0]       src_root;
    logic [TAG_BITS-1:0] src_tag;
    logic [RW-1:0]       rem_in;
    logic [RW-1:0]       trial;
    logic                ge;
    logic [RW-1:0]       rem_nxt;
    logic [RB-1:0]       root_nxt;
    logic [IN_BITS-1:0]  x_nxt;

    if (g == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_x    = in_x;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_tag  = in_tag;
    end else begin : g_next
      assign src_vld  = vld_r[g-1];
      assign src_x    = x_r[g-1];
      assign src_rem  = rem_r[g-1];
      assign src_root = root_r[g-1];
      assign src_tag  = tag_r[g-1];
    end

    assign rem_in   = {src_rem[RW-3:0], src_x[IN_BITS-1 -: 2]};
    assign trial    = {src_root, 2'b01};
    assign ge       = rem_in >= trial;
    assign rem_nxt  = ge ? rem_in - trial : rem_in;
    assign root_nxt = {src_root[RB-2:0], ge};
    assign x_nxt    = {src_x[IN_BITS-3:0], 2'b00};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= src_vld;
      end
      x_r[g]    <= x_nxt;
      rem_r[g]  <= rem_nxt;
      root_r[g] <= root_nxt;
      tag_r[g]  <= src_tag;
    end
  end

  assign out_vld  = vld_r[RB-1];
  assign out_root = root_r[RB-1];
  assign out_tag  = tag_r[RB-1];

endmodule

// ===== rtl/core/hac_div.sv =====
// Pipelined restoring fraction divider, one quotient bit per stage, with a side tag.
module hac_div #(
  parameter int NUM_BITS = 62,
  parameter int Q_BITS   = 30,
  parameter int TAG_BITS = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [NUM_BITS-1:0] in_num,
  input  logic [NUM_BITS-1:0] in_den,
  input  logic [TAG_BITS-1:0] in_tag,
  output logic                out_vld,
  output logic [Q_BITS-1:0]   out_q,
  output logic [TAG_BITS-1:0] out_tag
);

  logic                vld_r [Q_BITS];
  logic [NUM_BITS-1:0] rem_r [Q_BITS];
  logic [NUM_BITS-1:0] den_r [Q_BITS];
  logic [Q_BITS-1:0]   q_r   [Q_BITS];
  logic [TAG_BITS-1:0] tag_r [Q_BITS];

  for (genvar g = 0; g < Q_BITS; g++) begin : g_stage
    logic                src_vld;
    logic [NUM_BITS-1:0] src_rem;
    logic [NUM_BITS-1:0] src_den;
    logic [Q_BITS-1:0]   src_q;
    logic [TAG_BITS-1:0] src_tag;
    logic [NUM_BITS:0]   r2;
    logic [NUM_BITS:0]   diff;
    logic                ge;
    logic [NUM_BITS-1:0] rem_nxt;

    if (g == 0) begin : g_first
      assign src_vld = in_vld;
      assign src_rem = in_num;
      assign src_den = in_den;
      assign src_q   = '0;
      assign src_tag = in_tag;
    end else begin : g_next
      assign src_vld = vld_r[g-1];
      assign src_rem = rem_r[g-1];
      assign src_den = den_r[g-1];
      assign src_q   = q_r[g-1];
      assign src_tag = tag_r[g-1];
    end

    assign r2      = {src_rem, 1'b0};
    assign diff    = r2 - {1'b0, src_den};
    assign ge      = r2 >= {1'b0, src_den};
    assign rem_nxt = ge ? diff[NUM_BITS-1:0] : r2[NUM_BITS-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= src_vld;
      end
      rem_r[g] <= rem_nxt;
      den_r[g] <= src_den;
      q_r[g]   <= {src_q[Q_BITS-2:0], ge};
      tag_r[g] <= src_tag;
    end
  end

  assign out_vld = vld_r[Q_BITS-1];
  assign out_q   = q_r[Q_BITS-1];
  assign out_tag = tag_r[Q_BITS-1];

endmodule

// ===== rtl/core/hac_boost.sv =====
// Eight-stage scaled Lorentz boost of one four-vector followed by renormalisation.
module hac_boost (
  input  logic                              clk,
  input  logic [hac_pkg::NORM_BITS-1:0]     in_m,
  input  logic [hac_pkg::NORM_BITS:0]       in_s,
  input  hac_pkg::vec4_t                    in_mid,
  input  hac_pkg::vec4_t                    in_vec,
  output hac_pkg::vec3_t                    out_u,
  output logic                              out_zero
);

  localparam int NB   = hac_pkg::NORM_BITS;
  localparam int MS_W = 2 * NB + 1;
  localparam int DP_W = 2 * NB + 2;
  localparam int ES_W = 2 * NB + 3;
  localparam int DF_W = 2 * NB + 4;
  localparam int HL   = DF_W / 2;
  localparam int ML   = NB + 1;
  localparam int WB   = hac_pkg::WIDE_BITS;

  // B1
  logic [MS_W-1:0]        ms_r, ms_nxt;
  logic signed [DP_W-1:0] dpp_r [3];
  logic signed [DP_W-1:0] dpp_nxt [3];
  logic signed [ES_W-1:0] es_r, es_nxt;
  hac_pkg::vec4_t         d1_r, p1_r;
  // B2
  logic [MS_W-1:0]        ms2_r;
  logic signed [DF_W-1:0] diff_r, diff_nxt;
  hac_pkg::vec4_t         d2_r, p2_r;
  // B3
  logic signed [ES_W-1:0] pl_r [3];
  logic signed [ES_W-1:0] pl_nxt [3];
  logic signed [DP_W-1:0] ph_r [3];
  logic signed [DP_W-1:0] ph_nxt [3];
  logic signed [DF_W-1:0] dl_r [3];
  logic signed [DF_W-1:0] dl_nxt [3];
  logic signed [ES_W-1:0] dh_r [3];
  logic signed [ES_W-1:0] dh_nxt [3];
  // B4, B5
  logic signed [WB-1:0]   t1_r [3];
  logic signed [WB-1:0]   t1_nxt [3];
  logic signed [WB-1:0]   t2_r [3];
  logic signed [WB-1:0]   t2_nxt [3];
  logic signed [WB-1:0]   u_r [3];
  // B6, B7, B8
  hac_pkg::wide_t         mag_r [3];
  hac_pkg::wide_t         mag_nxt [3];
  logic                   neg_r [3];
  hac_pkg::wide_t         mag7_r [3];
  logic                   neg7_r [3];
  hac_pkg::len_t          len_r;
  hac_pkg::vec3_t         out_u_r, out_u_nxt;
  logic                   zero_r;

  always_comb begin
    logic signed [63:0] prod;
    logic signed [31:0] s_c;
    hac_pkg::comp_t     e_c;
    ms_nxt = MS_W'(in_m) * MS_W'(in_s);
    for (int i = 0; i < 3; i++) begin
      prod       = hac_pkg::smul(in_mid[i+1], in_vec[i+1]);
      dpp_nxt[i] = prod[DP_W-1:0];
    end
    e_c    = in_vec[0];
    s_c    = $signed({1'b0, in_s});
    es_nxt = ES_W'(e_c) * ES_W'(s_c);
  end

  always_comb begin
    diff_nxt = DF_W'(dpp_r[0]) + DF_W'(dpp_r[1]) + DF_W'(dpp_r[2]) - DF_W'(es_r);
  end

  always_comb begin
    hac_pkg::comp_t pc;
    hac_pkg::comp_t dc;
    for (int i = 0; i < 3; i++) begin
      pc        = p2_r[i+1];
      dc        = d2_r[i+1];
      pl_nxt[i] = ES_W'($signed({1'b0, ms2_r[ML-1:0]})) * ES_W'(pc);
      ph_nxt[i] = DP_W'($signed({1'b0, ms2_r[MS_W-1:ML]})) * DP_W'(pc);
      dl_nxt[i] = DF_W'($signed({1'b0, diff_r[HL-1:0]})) * DF_W'(dc);
      dh_nxt[i] = ES_W'($signed(diff_r[DF_W-1:HL])) * ES_W'(dc);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t1_nxt[i]  = (WB'(ph_r[i]) <<< ML) + WB'(pl_r[i]);
      t2_nxt[i]  = (WB'(dh_r[i]) <<< HL) + WB'(dl_r[i]);
      mag_nxt[i] = u_r[i][WB-1] ? hac_pkg::wide_t'(-u_r[i]) : hac_pkg::wide_t'(u_r[i]);
      out_u_nxt[i] = hac_pkg::apply_sign(hac_pkg::norm_mag(mag7_r[i], len_r), neg7_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    ms_r   <= ms_nxt;
    es_r   <= es_nxt;
    d1_r   <= in_mid;
    p1_r   <= in_vec;
    ms2_r  <= ms_r;
    diff_r <= diff_nxt;
    d2_r   <= d1_r;
    p2_r   <= p1_r;
    for (int i = 0; i < 3; i++) begin
      dpp_r[i]  <= dpp_nxt[i];
      pl_r[i]   <= pl_nxt[i];
      ph_r[i]   <= ph_nxt[i];
      dl_r[i]   <= dl_nxt[i];
      dh_r[i]   <= dh_nxt[i];
      t1_r[i]   <= t1_nxt[i];
      t2_r[i]   <= t2_nxt[i];
      u_r[i]    <= t1_r[i] + t2_r[i];
      mag_r[i]  <= mag_nxt[i];
      neg_r[i]  <= u_r[i][WB-1];
      mag7_r[i] <= mag_r[i];
      neg7_r[i] <= neg_r[i];
    end
    len_r   <= hac_pkg::bit_len(mag_r[0] | mag_r[1] | mag_r[2]);
    out_u_r <= out_u_nxt;
    zero_r  <= (len_r == '0);
  end

  assign out_u    = out_u_r;
  assign out_zero = zero_r;

endmodule

// ===== rtl/core/helicity_angle_cosine_core.sv =====
// Top level of the helicity-angle cosine core: input scaling, frame mass, boosts, cosine.
// Throughput: one transfer per cycle; busy falls at the first edge that sees rst_n high.
// The depth is set by the bit-per-stage square-root (30 and 31 stages) and divide (30) pipes.
// Reset: synchronous, active low; clears every valid bit and holds busy high while asserted.
// The receiver cannot stall: each result is shown for exactly one cycle.
module helicity_angle_cosine_core #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [WORD_BITS-2:0]        in_parent_energy,
  input  logic signed [WORD_BITS-1:0] in_parent_px,
  input  logic signed [WORD_BITS-1:0] in_parent_py,
  input  logic signed [WORD_BITS-1:0] in_parent_pz,
  input  logic [WORD_BITS-2:0]        in_mid_energy,
  input  logic signed [WORD_BITS-1:0] in_mid_px,
  input  logic signed [WORD_BITS-1:0] in_mid_py,
  input  logic signed [WORD_BITS-1:0] in_mid_pz,
  input  logic [WORD_BITS-2:0]        in_grand_energy,
  input  logic signed [WORD_BITS-1:0] in_grand_px,
  input  logic signed [WORD_BITS-1:0] in_grand_py,
  input  logic signed [WORD_BITS-1:0] in_grand_pz,
  output logic                        out_strobe,
  output logic signed [31:0]          out_cos_angle,
  output logic                        out_valid_res
);

  localparam int NB      = hac_pkg::NORM_BITS;
  localparam int BS      = hac_pkg::BOOST_STAGES;
  localparam int SQ_W    = 2 * NB + 2;
  localparam int UV_W    = 2 * NB + 3;
  localparam int LATENCY = 4 + NB + 1 + BS + 2 + (SQ_W / 2) + 2 + hac_pkg::COS_FRAC + 1;

  logic busy_r;
  logic accept;

  // S1: magnitudes and leading-one position per four-vector
  logic [WORD_BITS-1:0] raw [12];
  logic [WORD_BITS-1:0] mag_nxt [12];
  logic                 neg_nxt [12];
  hac_pkg::len_t        len_nxt [3];
  logic [WORD_BITS-1:0] mag_r [12];
  logic                 neg_r [12];
  hac_pkg::len_t        len_r [3];
  logic                 vld1_r;
  // S2: normalised vectors
  hac_pkg::vec4_t       vec_nxt [3];
  hac_pkg::vec4_t       vec_r [3];
  logic                 vld2_r;
  // S3: daughter squares
  logic [2*NB-1:0]      sq_nxt [4];
  logic [2*NB-1:0]      sq_r [4];
  hac_pkg::vec4_t       vec3_r [3];
  logic                 vld3_r;
  // S4: invariant mass squared
  logic [SQ_W-1:0]      d2_sum;
  logic [2*NB-1:0]      x_r;
  hac_pkg::frame_tag_t  ftag_r;
  logic                 vld4_r;
  // mass root
  logic                 sq1_vld;
  logic [NB-1:0]        sq1_root;
  hac_pkg::frame_tag_t  sq1_tag;
  // S5: m and E + m
  logic [NB-1:0]        m_r;
  logic [NB:0]          s_r;
  hac_pkg::frame_tag_t  ftag5_r;
  logic                 vld5_r;
  // boosts
  hac_pkg::vec3_t       u_vec, v_vec;
  logic                 u_zero, v_zero;
  logic                 ok_dly_r [BS];
  logic                 vld_dly_r [BS];
  // S6, S7: dot products
  logic [2*NB-1:0]        puu_nxt [3];
  logic [2*NB-1:0]        pvv_nxt [3];
  logic signed [2*NB+1:0] puv_nxt [3];
  logic [2*NB-1:0]        puu_r [3];
  logic [2*NB-1:0]        pvv_r [3];
  logic signed [2*NB+1:0] puv_r [3];
  logic                   ok6_r, vld6_r;
  logic [SQ_W-1:0]        uu_r, vv_r;
  logic signed [UV_W-1:0] uv_r;
  logic                   ok7_r, vld7_r;
  // magnitude roots
  logic                   sqa_vld, sqb_vld;
  logic [SQ_W/2-1:0]      sqa_root, sqb_root;
  logic signed [UV_W-1:0] sqa_uv;
  logic                   sqb_ok;
  // S8, S9: denominator and divider set-up
  logic [SQ_W-1:0]        den_r;
  logic [UV_W-1:0]        n_r;
  logic                   neg8_r, ok8_r, vld8_r;
  logic [SQ_W-1:0]        dn_r, dd_r;
  hac_pkg::div_tag_t      dtag_r, dtag_nxt;
  logic                   vld9_r;
  // divider and output
  logic                       div_vld;
  logic [hac_pkg::COS_FRAC-1:0] div_q;
  hac_pkg::div_tag_t          div_tag;
  logic signed [31:0]         res;
  logic signed [31:0]         cos_nxt;
  logic                       out_strobe_r;
  logic signed [31:0]         out_cos_angle_r;
  logic                       out_valid_res_r;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  assign raw[0]  = {1'b0, in_parent_energy};
  assign raw[1]  = in_parent_px;
  assign raw[2]  = in_parent_py;
  assign raw[3]  = in_parent_pz;
  assign raw[4]  = {1'b0, in_mid_energy};
  assign raw[5]  = in_mid_px;
  assign raw[6]  = in_mid_py;
  assign raw[7]  = in_mid_pz;
  assign raw[8]  = {1'b0, in_grand_energy};
  assign raw[9]  = in_grand_px;
  assign raw[10] = in_grand_py;
  assign raw[11] = in_grand_pz;

  always_comb begin
    for (int j = 0; j < 12; j++) begin
      if ((j & 3) == 0) begin
        neg_nxt[j] = 1'b0;
        mag_nxt[j] = raw[j];
      end else begin
        neg_nxt[j] = raw[j][WORD_BITS-1];
        mag_nxt[j] = neg_nxt[j] ? (~raw[j] + 1'b1) : raw[j];
      end
    end
    for (int k = 0; k < 3; k++) begin
      len_nxt[k] = hac_pkg::bit_len(hac_pkg::wide_t'(mag_nxt[4*k] | mag_nxt[4*k+1] |
                                                     mag_nxt[4*k+2] | mag_nxt[4*k+3]));
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 4; c++) begin
        vec_nxt[k][c] = hac_pkg::apply_sign(
          hac_pkg::norm_mag(hac_pkg::wide_t'(mag_r[4*k+c]), len_r[k]), neg_r[4*k+c]);
      end
    end
  end

  always_comb begin
    logic signed [63:0] prod;
    for (int c = 0; c < 4; c++) begin
      prod      = hac_pkg::smul(vec_r[1][c], vec_r[1][c]);
      sq_nxt[c] = prod[2*NB-1:0];
    end
  end

  assign d2_sum = SQ_W'(sq_r[1]) + SQ_W'(sq_r[2]) + SQ_W'(sq_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      busy_r <= 1'b0;
      vld1_r <= accept;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
    for (int j = 0; j < 12; j++) begin
      mag_r[j] <= mag_nxt[j];
      neg_r[j] <= neg_nxt[j];
    end
    for (int k = 0; k < 3; k++) begin
      len_r[k]  <= len_nxt[k];
      vec_r[k]  <= vec_nxt[k];
      vec3_r[k] <= vec_r[k];
    end
    for (int c = 0; c < 4; c++) begin
      sq_r[c] <= sq_nxt[c];
    end
    x_r        <= sq_r[0] - d2_sum[2*NB-1:0];
    ftag_r.par <= vec3_r[0];
    ftag_r.mid <= vec3_r[1];
    ftag_r.grd <= vec3_r[2];
    ftag_r.ok  <= SQ_W'(sq_r[0]) > d2_sum;
  end

  hac_isqrt #(
    .IN_BITS  (2 * NB),
    .TAG_BITS ($bits(hac_pkg::frame_tag_t))
  ) u_sq_mass (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld4_r),
    .in_x     (x_r),
    .in_tag   (ftag_r),
    .out_vld  (sq1_vld),
    .out_root (sq1_root),
    .out_tag  (sq1_tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else begin
      vld5_r <= sq1_vld;
    end
    m_r     <= sq1_root;
    s_r     <= (NB+1)'(sq1_tag.mid[0][NB-1:0]) + (NB+1)'(sq1_root);
    ftag5_r <= sq1_tag;
  end

  hac_boost u_boost_par (
    .clk      (clk),
    .in_m     (m_r),
    .in_s     (s_r),
    .in_mid   (ftag5_r.mid),
    .in_vec   (ftag5_r.par),
    .out_u    (u_vec),
    .out_zero (u_zero)
  );

  hac_boost u_boost_grd (
    .clk      (clk),
    .in_m     (m_r),
    .in_s     (s_r),
    .in_mid   (ftag5_r.mid),
    .in_vec   (ftag5_r.grd),
    .out_u    (v_vec),
    .out_zero (v_zero)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BS; i++) vld_dly_r[i] <= 1'b0;
    end else begin
      vld_dly_r[0] <= vld5_r;
      for (int i = 1; i < BS; i++) vld_dly_r[i] <= vld_dly_r[i-1];
    end
    ok_dly_r[0] <= ftag5_r.ok;
    for (int i = 1; i < BS; i++) ok_dly_r[i] <= ok_dly_r[i-1];
  end

  always_comb begin
    logic signed [63:0] pu, pv, pw;
    for (int c = 0; c < 3; c++) begin
      pu         = hac_pkg::smul(u_vec[c], u_vec[c]);
      pv         = hac_pkg::smul(v_vec[c], v_vec[c]);
      pw         = hac_pkg::smul(u_vec[c], v_vec[c]);
      puu_nxt[c] = pu[2*NB-1:0];
      pvv_nxt[c] = pv[2*NB-1:0];
      puv_nxt[c] = pw[2*NB+1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else begin
      vld6_r <= vld_dly_r[BS-1];
      vld7_r <= vld6_r;
    end
    for (int c = 0; c < 3; c++) begin
      puu_r[c] <= puu_nxt[c];
      pvv_r[c] <= pvv_nxt[c];
      puv_r[c] <= puv_nxt[c];
    end
    ok6_r <= ok_dly_r[BS-1] && !u_zero && !v_zero;
    uu_r  <= SQ_W'(puu_r[0]) + SQ_W'(puu_r[1]) + SQ_W'(puu_r[2]);
    vv_r  <= SQ_W'(pvv_r[0]) + SQ_W'(pvv_r[1]) + SQ_W'(pvv_r[2]);
    uv_r  <= UV_W'(puv_r[0]) + UV_W'(puv_r[1]) + UV_W'(puv_r[2]);
    ok7_r <= ok6_r;
  end

  hac_isqrt #(
    .IN_BITS  (SQ_W),
    .TAG_BITS (UV_W)
  ) u_sq_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld7_r),
    .in_x     (uu_r),
    .in_tag   (uv_r),
    .out_vld  (sqa_vld),
    .out_root (sqa_root),
    .out_tag  (sqa_uv)
  );

  hac_isqrt #(
    .IN_BITS  (SQ_W),
    .TAG_BITS (1)
  ) u_sq_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld7_r),
    .in_x     (vv_r),
    .in_tag   (ok7_r),
    .out_vld  (sqb_vld),
    .out_root (sqb_root),
    .out_tag  (sqb_ok)
  );

  always_comb begin
    dtag_nxt.neg = neg8_r;
    dtag_nxt.sat = n_r >= {1'b0, den_r};
    dtag_nxt.ok  = ok8_r && (den_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld8_r <= 1'b0;
      vld9_r <= 1'b0;
    end else begin
      vld8_r <= sqa_vld;
      vld9_r <= vld8_r;
    end
    den_r  <= SQ_W'(sqa_root) * SQ_W'(sqb_root);
    n_r    <= sqa_uv[UV_W-1] ? UV_W'(-sqa_uv) : UV_W'(sqa_uv);
    neg8_r <= sqa_uv[UV_W-1];
    ok8_r  <= sqb_ok;
    dn_r   <= dtag_nxt.sat ? '0 : n_r[SQ_W-1:0];
    dd_r   <= den_r;
    dtag_r <= dtag_nxt;
  end

  hac_div #(
    .NUM_BITS (SQ_W),
    .Q_BITS   (hac_pkg::COS_FRAC),
    .TAG_BITS ($bits(hac_pkg::div_tag_t))
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld9_r),
    .in_num  (dn_r),
    .in_den  (dd_r),
    .in_tag  (dtag_r),
    .out_vld (div_vld),
    .out_q   (div_q),
    .out_tag (div_tag)
  );

  always_comb begin
    res = div_tag.sat ? 32'(hac_pkg::COS_ONE) : 32'(div_q);
    if (!div_tag.ok) cos_nxt = '0;
    else cos_nxt = div_tag.neg ? -res : res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= div_vld;
    end
    out_cos_angle_r <= cos_nxt;
    out_valid_res_r <= div_tag.ok;
  end

  assign out_strobe    = out_strobe_r;
  assign out_cos_angle = out_cos_angle_r;
  assign out_valid_res = out_valid_res_r;

  a_root_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    sqa_vld == sqb_vld)
    else $error("magnitude root pipes out of step");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_valid_res |-> out_cos_angle == 32'sd0)
    else $error("invalid result carries a non-zero cosine");

  a_cos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_valid_res |->
      (out_cos_angle <= 32'sd1073741824) && (out_cos_angle >= -32'sd1073741824))
    else $error("cosine outside unit range");

  a_busy_clears: assert property (@(posedge clk) rst_n |=> !busy)
    else $error("busy held after reset");

  a_strobe_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LATENCY))
    else $error("result with no matching transfer");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the helicity-angle cosine core: random and corner four-momenta.
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic [30:0]        pe, me, ge;
    logic signed [31:0] px, py, pz, mx, my, mz, gx, gy, gz;
  } decay_t;

  typedef struct {
    logic signed [31:0] cosv;
    logic               ok;
  } cosine_t;

  localparam int FLUSH_CYCLES = 130;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [30:0] in_parent_energy = '0, in_mid_energy = '0, in_grand_energy = '0;
  logic signed [31:0] in_parent_px = '0, in_parent_py = '0, in_parent_pz = '0;
  logic signed [31:0] in_mid_px = '0, in_mid_py = '0, in_mid_pz = '0;
  logic signed [31:0] in_grand_px = '0, in_grand_py = '0, in_grand_pz = '0;
  logic out_strobe;
  logic signed [31:0] out_cos_angle;
  logic out_valid_res;

  decay_t  pending_decays[$];
  cosine_t expected_cosines[$];
  int      fail_count = 0;
  int      loaded = 0;
  int      gap = 0;

  helicity_angle_cosine_core DUT (
    .clk, .rst_n, .start, .busy,
    .in_parent_energy, .in_parent_px, .in_parent_py, .in_parent_pz,
    .in_mid_energy, .in_mid_px, .in_mid_py, .in_mid_pz,
    .in_grand_energy, .in_grand_px, .in_grand_py, .in_grand_pz,
    .out_strobe, .out_cos_angle, .out_valid_res
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int len128(input logic [127:0] x);
    int n;
    n = 0;
    for (int i = 0; i < 128; i++) if (x[i]) n = i + 1;
    return n;
  endfunction

  // scale a four-vector to 30 significant bits, truncating magnitudes
  function automatic void scale4(input logic [30:0] e, input logic signed [31:0] x,
                                 input logic signed [31:0] y, input logic signed [31:0] z,
                                 output longint v[4]);
    logic [63:0] mag[4];
    logic        neg[4];
    logic signed [31:0] c[3];
    int len;
    c[0] = x; c[1] = y; c[2] = z;
    mag[0] = 64'(e);
    neg[0] = 1'b0;
    for (int i = 1; i < 4; i++) begin
      neg[i] = c[i-1][31];
      mag[i] = neg[i] ? 64'(-longint'(c[i-1])) : 64'(longint'(c[i-1]));
    end
    len = len128(128'(mag[0] | mag[1] | mag[2] | mag[3]));
    for (int i = 0; i < 4; i++) begin
      if (len > 30) mag[i] = mag[i] >> (len - 30);
      else if (len > 0) mag[i] = mag[i] << (30 - len);
      v[i] = neg[i] ? -longint'(mag[i]) : longint'(mag[i]);
    end
  endfunction

  // boosted momentum times m*s, normalised; returns 0 when zero
  function automatic bit boost_norm(input longint d[4], input longint m, input longint s,
                                    input longint p[4], output longint u[3]);
    longint dp, diff;
    logic signed [127:0] w[3];
    logic [127:0] mag[3];
    int len;
    dp = d[1] * p[1] + d[2] * p[2] + d[3] * p[3];
    diff = dp - p[0] * s;
    for (int i = 0; i < 3; i++) begin
      w[i] = 128'(m * s) * 128'(p[i+1]) + 128'(d[i+1]) * 128'(diff);
      mag[i] = w[i][127] ? -w[i] : w[i];
    end
    len = len128(mag[0] | mag[1] | mag[2]);
    if (len == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (len > 30) mag[i] = mag[i] >> (len - 30);
      else mag[i] = mag[i] << (30 - len);
      u[i] = w[i][127] ? -longint'(mag[i][29:0]) : longint'(mag[i][29:0]);
    end
    return 1'b1;
  endfunction

  function automatic cosine_t predict_cosine(input decay_t t);
    cosine_t r;
    longint par[4], mid[4], grd[4], u[3], v[3], m, s, uv;
    logic [63:0] e2, d2, uu, vv, den;
    logic [127:0] n, q;
    r.cosv = 0;
    r.ok = 1'b0;
    scale4(t.pe, t.px, t.py, t.pz, par);
    scale4(t.me, t.mx, t.my, t.mz, mid);
    scale4(t.ge, t.gx, t.gy, t.gz, grd);
    e2 = mid[0] * mid[0];
    d2 = mid[1] * mid[1] + mid[2] * mid[2] + mid[3] * mid[3];
    if (e2 <= d2) return r;
    m = longint'(isqrt(e2 - d2));
    s = mid[0] + m;
    if (!boost_norm(mid, m, s, par, u)) return r;
    if (!boost_norm(mid, m, s, grd, v)) return r;
    uu = 0; vv = 0; uv = 0;
    for (int i = 0; i < 3; i++) begin
      uu += u[i] * u[i];
      vv += v[i] * v[i];
      uv += u[i] * v[i];
    end
    den = isqrt(uu) * isqrt(vv);
    if (den == 0) return r;
    n = uv < 0 ? 128'(-uv) : 128'(uv);
    q = (n << 30) / 128'(den);
    if (q > (128'd1 << 30)) q = 128'd1 << 30;
    r.cosv = uv < 0 ? -32'(q) : 32'(q);
    r.ok = 1'b1;
    return r;
  endfunction

  function automatic logic signed [31:0] scaled_comp(input int sh);
    return $signed($urandom) >>> sh;
  endfunction

  function automatic decay_t random_decay();
    decay_t t;
    int sh;
    longint a;
    if ($urandom_range(0, 4) == 0) begin
      {t.pe, t.me, t.ge} = {31'($urandom), 31'($urandom), 31'($urandom)};
      {t.px, t.py, t.pz} = {$urandom, $urandom, $urandom};
      {t.mx, t.my, t.mz} = {$urandom, $urandom, $urandom};
      {t.gx, t.gy, t.gz} = {$urandom, $urandom, $urandom};
      return t;
    end
    sh = $urandom_range(2, 30);
    t.mx = scaled_comp(sh); t.my = scaled_comp(sh); t.mz = scaled_comp(sh);
    a = (t.mx < 0 ? -longint'(t.mx) : t.mx) + (t.my < 0 ? -longint'(t.my) : t.my)
      + (t.mz < 0 ? -longint'(t.mz) : t.mz) + $urandom_range(0, 1 << (31 - sh));
    t.me = a > 64'h7FFFFFFF ? 31'h7FFFFFFF : 31'(a);
    sh = $urandom_range(1, 30);
    t.px = scaled_comp(sh); t.py = scaled_comp(sh); t.pz = scaled_comp(sh);
    t.pe = 31'($urandom) >> (sh - 1);
    sh = $urandom_range(1, 30);
    t.gx = scaled_comp(sh); t.gy = scaled_comp(sh); t.gz = scaled_comp(sh);
    t.ge = 31'($urandom) >> (sh - 1);
    return t;
  endfunction

  function automatic decay_t make_decay(input logic [30:0] pe, input int px, input int py,
                                        input int pz, input logic [30:0] me, input int mx,
                                        input int my, input int mz, input logic [30:0] ge,
                                        input int gx, input int gy, input int gz);
    decay_t t;
    t.pe = pe; t.px = px; t.py = py; t.pz = pz;
    t.me = me; t.mx = mx; t.my = my; t.mz = mz;
    t.ge = ge; t.gx = gx; t.gy = gy; t.gz = gz;
    return t;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) expected_cosines.push_back(predict_cosine(make_decay(
        in_parent_energy, in_parent_px, in_parent_py, in_parent_pz,
        in_mid_energy, in_mid_px, in_mid_py, in_mid_pz,
        in_grand_energy, in_grand_px, in_grand_py, in_grand_pz)));
      if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (loaded == 450 && expected_cosines.size() > 0) begin
        start <= 1'b0;
      end else if (pending_decays.size() > 0) begin
        decay_t t;
        t = pending_decays.pop_front();
        in_parent_energy <= t.pe; in_parent_px <= t.px;
        in_parent_py <= t.py; in_parent_pz <= t.pz;
        in_mid_energy <= t.me; in_mid_px <= t.mx;
        in_mid_py <= t.my; in_mid_pz <= t.mz;
        in_grand_energy <= t.ge; in_grand_px <= t.gx;
        in_grand_py <= t.gy; in_grand_pz <= t.gz;
        start <= 1'b1;
        loaded++;
        gap = ((loaded / 100) % 3 == 0) ? 0 : $urandom_range(0, 5);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_cosines.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        cosine_t e;
        e = expected_cosines.pop_front();
        if (out_cos_angle !== e.cosv) begin
          $error("cos_angle expected %0d actual %0d", e.cosv, out_cos_angle);
          fail_count++;
        end
        if (out_valid_res !== e.ok) begin
          $error("valid_res expected %0d actual %0d", e.ok, out_valid_res);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int mn, mx;
    mn = 32'h80000000;
    mx = 32'h7FFFFFFF;
    pending_decays.push_back(make_decay(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_decays.push_back(make_decay(1000, 3, 4, 5, 1000, 1000, 0, 0, 900, 7, 8, 9));
    pending_decays.push_back(make_decay(1000, 3, 4, 5, 500, 300, 400, 0, 900, 7, 8, 9));
    pending_decays.push_back(make_decay(0, 0, 0, 0, 1 << 20, 0, 0, 0, 5000, 10, 0, 0));
    pending_decays.push_back(make_decay(5000, 10, 0, 0, 1 << 20, 0, 0, 0, 0, 0, 0, 0));
    pending_decays.push_back(make_decay(9000, 100, 200, 300, 1 << 20, 5, 6, 7,
                                        9000, 100, 200, 300));
    pending_decays.push_back(make_decay(9000, 100, 200, 300, 1 << 20, 0, 0, 0,
                                        9000, -100, -200, -300));
    pending_decays.push_back(make_decay(31'h7FFFFFFF, mn, mn, mn, 31'h7FFFFFFF, 1, -1, 0,
                                        31'h7FFFFFFF, mx, mx, mx));
    pending_decays.push_back(make_decay(31'h7FFFFFFF, mx, mn, mx, 31'h7FFFFFFF, mx, 0, 0,
                                        1, mn, mx, mn));
    pending_decays.push_back(make_decay(1, -1, 1, -1, 31'h7FFFFFFF, 0, 0, mn,
                                        31'h7FFFFFFF, 0, 0, 0));
    pending_decays.push_back(make_decay(2, 1, 0, 0, 1, 0, 0, 0, 2, 0, 1, 0));
    pending_decays.push_back(make_decay(1 << 21, 1 << 20, 0, 0, 1 << 22, 1 << 21, 0, 0,
                                        1 << 21, 0, 1 << 20, 0));
    pending_decays.push_back(make_decay(0, 0, 0, 0, 31'h7FFFFFFF, mn, mn, mn,
                                        0, 0, 0, 0));
    pending_decays.push_back(make_decay(31'h7FFFFFFF, 0, 0, 0, 31'h7FFFFFFF, 0, 0, 0,
                                        31'h7FFFFFFF, 0, 0, 0));
    repeat (900) pending_decays.push_back(random_decay());
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_decays.size() > 0 || start || expected_cosines.size() > 0)
      @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (expected_cosines.size() != 0) begin
      $error("results missing: %0d", expected_cosines.size());
      fail_count++;
    end
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
